@@ rtl/heightmap_normal_encode_top_assert.svh @@
// Assertion macros used by the heightmap normal encoder RTL.
`ifndef HEIGHTMAP_NORMAL_ENCODE_TOP_ASSERT_SVH
`define HEIGHTMAP_NORMAL_ENCODE_TOP_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define HNE_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define HNE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/hne_pkg.sv @@
// Shared types and constants of the heightmap normal encoder.
`default_nettype none
package hne_pkg;
    // Width of a signed Q.16 unit-vector component
    localparam int OW = 18;
    // Quotient bits of the normalizing divide
    localparam int QW = 17;
    // Width of the signed sum of four Q.16 unit vectors
    localparam int SW = 20;
    // Fraction bits of the vector length in the first and second pass
    localparam int G_FIRST  = 12;
    localparam int G_SECOND = 10;

    typedef logic signed [OW-1:0] comp_t;

    localparam comp_t ONE_Q16 = comp_t'(65536);

    // Map a Q.16 component from -1..1 to 0..1, clamp low, saturate high.
    function automatic logic [15:0] encode(comp_t c);
        logic signed [OW:0] t;
        logic [OW-1:0] e;
        t = {c[OW-1], c} + {1'b0, ONE_Q16};
        if (t[OW])
        begin
            e = '0;
        end
        else
        begin
            e = {1'b0, t[OW-1:1]};
        end
        if (e[OW-1:16] != '0)
        begin
            return 16'hFFFF;
        end
        return e[15:0];
    endfunction
endpackage
`default_nettype wire

@@ rtl/heightmap_normal_encode_top.sv @@
// Heightmap normal encoder top level: 3x3 heights in, encoded (z,x,y) normal out.
// Each of the two normalizer passes is a bit-serial square root and a 17-step divide.
// Throughput: one transaction per cycle while the receiver takes results; a stalled
// result parks in the skid register and input waits until it leaves.
// Reset: rst_n clears all valid bits, including the skid valid bit, at once; no clearing pass.
`default_nettype none
`include "heightmap_normal_encode_top_assert.svh"
module heightmap_normal_encode_top #(
    parameter int HEIGHT_BITS = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [HEIGHT_BITS-1:0] h_center,
    input  logic [HEIGHT_BITS-1:0] h_north,
    input  logic [HEIGHT_BITS-1:0] h_south,
    input  logic [HEIGHT_BITS-1:0] h_east,
    input  logic [HEIGHT_BITS-1:0] h_west,
    input  logic [HEIGHT_BITS-1:0] h_northeast,
    input  logic [HEIGHT_BITS-1:0] h_southeast,
    input  logic [HEIGHT_BITS-1:0] h_northwest,
    input  logic [HEIGHT_BITS-1:0] h_southwest,
    input  logic                   interior,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [15:0]            enc_z,
    output logic [15:0]            enc_x,
    output logic [15:0]            enc_y
);
    localparam int HB  = HEIGHT_BITS;
    localparam int C1  = HB + 2;
    localparam int OW  = hne_pkg::OW;
    localparam int SW  = hne_pkg::SW;
    localparam int SBW = 1 + 3 * OW;

    logic en;
    logic skid_v_reg;

    // Advance the whole pipeline unless the skid register is holding
    assign en       = !skid_v_reg;
    assign in_ready = en;

    // Input stage: height differences and the four raw normals
    logic signed [HB:0]   d_n, d_s, d_e, d_w, d_ne, d_se, d_nw, d_sw;
    logic signed [C1-1:0] nx_next [4];
    logic signed [C1-1:0] nz_next [4];
    logic signed [C1-1:0] nx_reg  [4];
    logic signed [C1-1:0] nz_reg  [4];
    logic                 int_reg;
    logic                 t0_v_reg;

    always_comb
    begin
        d_n  = $signed({1'b0, h_north})     - $signed({1'b0, h_center});
        d_s  = $signed({1'b0, h_south})     - $signed({1'b0, h_center});
        d_e  = $signed({1'b0, h_east})      - $signed({1'b0, h_center});
        d_w  = $signed({1'b0, h_west})      - $signed({1'b0, h_center});
        d_ne = $signed({1'b0, h_northeast}) - $signed({1'b0, h_center});
        d_se = $signed({1'b0, h_southeast}) - $signed({1'b0, h_center});
        d_nw = $signed({1'b0, h_northwest}) - $signed({1'b0, h_center});
        d_sw = $signed({1'b0, h_southwest}) - $signed({1'b0, h_center});
        nx_next[0] = -C1'(d_s);
        nz_next[0] = -C1'(d_e);
        nx_next[1] = C1'(d_n);
        nz_next[1] = C1'(d_w);
        nx_next[2] = -C1'(d_ne) - C1'(d_se);
        nz_next[2] = C1'(d_se) - C1'(d_ne);
        nx_next[3] = C1'(d_sw) + C1'(d_nw);
        nz_next[3] = C1'(d_sw) - C1'(d_nw);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nx_reg  <= nx_next;
            nz_reg  <= nz_next;
            int_reg <= interior;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t0_v_reg <= 1'b0;
        end
        else if (en)
        begin
            t0_v_reg <= in_valid;
        end
    end

    // First pass: normalize the four normals side by side
    hne_pkg::comp_t ux [4];
    hne_pkg::comp_t uy [4];
    hne_pkg::comp_t uz [4];
    logic [3:0]     uv;
    logic [3:0]     us;

    for (genvar j = 0; j < 4; j++)
    begin : g_first
        localparam logic signed [C1-1:0] NY = (j < 2) ? C1'(1) : C1'(2);

        hne_unit #(
            .CW  (C1),
            .G   (hne_pkg::G_FIRST),
            .SBW (1)
        ) u_unit (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (t0_v_reg),
            .in_x      (nx_reg[j]),
            .in_y      (NY),
            .in_z      (nz_reg[j]),
            .in_side   (int_reg),
            .out_valid (uv[j]),
            .out_x     (ux[j]),
            .out_y     (uy[j]),
            .out_z     (uz[j]),
            .out_side  (us[j])
        );
    end

    // Sum stage: add the four unit vectors, carry the lone first normal along
    logic signed [SW-1:0] sx_reg, sy_reg, sz_reg;
    logic [SBW-1:0]       sside_reg;
    logic                 sv_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sx_reg <= SW'(ux[0]) + SW'(ux[1]) + SW'(ux[2]) + SW'(ux[3]);
            sy_reg <= SW'(uy[0]) + SW'(uy[1]) + SW'(uy[2]) + SW'(uy[3]);
            sz_reg <= SW'(uz[0]) + SW'(uz[1]) + SW'(uz[2]) + SW'(uz[3]);
            sside_reg <= {us[0], ux[0], uy[0], uz[0]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sv_reg <= 1'b0;
        end
        else if (en)
        begin
            sv_reg <= uv[0];
        end
    end

    // Second pass: normalize the sum
    hne_pkg::comp_t fx, fy, fz;
    logic [SBW-1:0] f_side;
    logic           f_v;

    hne_unit #(
        .CW  (SW),
        .G   (hne_pkg::G_SECOND),
        .SBW (SBW)
    ) u_second (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sv_reg),
        .in_x      (sx_reg),
        .in_y      (sy_reg),
        .in_z      (sz_reg),
        .in_side   (sside_reg),
        .out_valid (f_v),
        .out_x     (fx),
        .out_y     (fy),
        .out_z     (fz),
        .out_side  (f_side)
    );

    // Encode stage: pick the averaged or the lone normal, map to 0..1
    hne_pkg::comp_t cx, cy, cz;
    logic           f_int;
    logic [15:0]    oz_reg, ox_reg, oy_reg;
    logic           ov_reg;

    assign f_int = f_side[3*OW];
    assign cx    = f_int ? fx : hne_pkg::comp_t'(f_side[3*OW-1:2*OW]);
    assign cy    = f_int ? fy : hne_pkg::comp_t'(f_side[2*OW-1:OW]);
    assign cz    = f_int ? fz : hne_pkg::comp_t'(f_side[OW-1:0]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            oz_reg <= hne_pkg::encode(cz);
            ox_reg <= hne_pkg::encode(cx);
            oy_reg <= hne_pkg::encode(cy);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else if (en)
        begin
            ov_reg <= f_v;
        end
    end

    // Skid register: catch the result when the pipeline advances into a stall
    logic [15:0] kz_reg, kx_reg, ky_reg;
    logic        skid_load;

    assign skid_load = en && ov_reg && !out_ready;

    always_ff @(posedge clk)
    begin
        if (skid_load)
        begin
            kz_reg <= oz_reg;
            kx_reg <= ox_reg;
            ky_reg <= oy_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_v_reg <= 1'b0;
        end
        else if (skid_load)
        begin
            skid_v_reg <= 1'b1;
        end
        else if (skid_v_reg && out_ready)
        begin
            skid_v_reg <= 1'b0;
        end
    end

    assign out_valid = skid_v_reg || ov_reg;
    assign enc_z     = skid_v_reg ? kz_reg : oz_reg;
    assign enc_x     = skid_v_reg ? kx_reg : ox_reg;
    assign enc_y     = skid_v_reg ? ky_reg : oy_reg;

    // Check lane alignment and skid behavior
    `HNE_ASSERT_SAME(a_lanes_aligned, uv[0] || uv[1] || uv[2] || uv[3], uv == 4'b1111, "first-pass lanes out of step")
    `HNE_ASSERT_SAME(a_lanes_side, uv[0], us == {4{us[0]}}, "first-pass lanes disagree on interior flag")
    `HNE_ASSERT_NEXT(a_skid_catch, skid_load, skid_v_reg && enc_z == $past(oz_reg) && enc_x == $past(ox_reg), "stalled result not caught by skid register")
    `HNE_ASSERT_NEXT(a_skid_hold, skid_v_reg && !out_ready, skid_v_reg && $stable(kz_reg) && $stable(ov_reg), "skid register or pipeline moved during stall")
endmodule
`default_nettype wire

@@ rtl/hne_unit.sv @@
// Pipelined unit-vector normalizer: squares, bit-serial square root, restoring divide.
`default_nettype none
module hne_unit #(
    parameter int CW  = 10,
    parameter int G   = 12,
    parameter int SBW = 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic signed [CW-1:0] in_x,
    input  logic signed [CW-1:0] in_y,
    input  logic signed [CW-1:0] in_z,
    input  logic [SBW-1:0]       in_side,
    output logic                 out_valid,
    output hne_pkg::comp_t       out_x,
    output hne_pkg::comp_t       out_y,
    output hne_pkg::comp_t       out_z,
    output logic [SBW-1:0]       out_side
);
    localparam int LW = 2 * CW;
    localparam int AW = LW + 2 * G;
    localparam int RW = CW + G;
    localparam int QW = hne_pkg::QW;
    localparam int NW = CW + 16 + G;
    localparam int DW = RW + QW;

    // Stage 1: magnitudes, signs and squares
    logic [2:0][CW-1:0] vin;
    logic [2:0][CW-1:0] mag_next, mag_reg;
    logic [2:0]         sgn_next, sgn_reg;
    logic [2:0][LW-1:0] sq_next, sq_reg;
    logic [SBW-1:0]     side1_reg;
    logic               v1_reg;

    assign vin = {in_z, in_y, in_x};

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sgn_next[i] = vin[i][CW-1];
            mag_next[i] = vin[i][CW-1] ? CW'(-vin[i]) : vin[i];
            sq_next[i]  = mag_next[i] * mag_next[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg   <= mag_next;
            sgn_reg   <= sgn_next;
            sq_reg    <= sq_next;
            side1_reg <= in_side;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
        end
    end

    // Square root stages: one root bit per stage
    logic [AW-1:0]      sr_arg_reg  [0:RW];
    logic [RW+1:0]      sr_rem_reg  [0:RW];
    logic [RW-1:0]      sr_root_reg [0:RW];
    logic [2:0][CW-1:0] sr_mag_reg  [0:RW];
    logic [2:0]         sr_sgn_reg  [0:RW];
    logic               sr_zero_reg [0:RW];
    logic [SBW-1:0]     sr_side_reg [0:RW];
    logic               sr_v_reg    [0:RW];
    logic [LW-1:0]      len_next;

    assign len_next = sq_reg[0] + sq_reg[1] + sq_reg[2];

    // Load the squared length, scaled by the fraction bits
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sr_arg_reg[0]  <= {len_next, {(2 * G){1'b0}}};
            sr_rem_reg[0]  <= '0;
            sr_root_reg[0] <= '0;
            sr_mag_reg[0]  <= mag_reg;
            sr_sgn_reg[0]  <= sgn_reg;
            sr_zero_reg[0] <= (len_next == '0);
            sr_side_reg[0] <= side1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sr_v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            sr_v_reg[0] <= v1_reg;
        end
    end

    for (genvar i = 0; i < RW; i++)
    begin : g_sqrt
        logic [RW+1:0] rem_sh;
        logic [RW+1:0] trial;
        logic [RW+1:0] rem_next;
        logic [RW-1:0] root_next;

        // Bring down two bits and try the next root bit
        always_comb
        begin
            rem_sh = {sr_rem_reg[i][RW-1:0], sr_arg_reg[i][AW-1:AW-2]};
            trial  = {sr_root_reg[i], 2'b01};
            if (rem_sh >= trial)
            begin
                rem_next  = rem_sh - trial;
                root_next = {sr_root_reg[i][RW-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh;
                root_next = {sr_root_reg[i][RW-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sr_arg_reg[i+1]  <= sr_arg_reg[i] << 2;
                sr_rem_reg[i+1]  <= rem_next;
                sr_root_reg[i+1] <= root_next;
                sr_mag_reg[i+1]  <= sr_mag_reg[i];
                sr_sgn_reg[i+1]  <= sr_sgn_reg[i];
                sr_zero_reg[i+1] <= sr_zero_reg[i];
                sr_side_reg[i+1] <= sr_side_reg[i];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sr_v_reg[i+1] <= 1'b0;
            end
            else if (en)
            begin
                sr_v_reg[i+1] <= sr_v_reg[i];
            end
        end
    end

    // Divide stages: one quotient bit per stage, three lanes
    logic [2:0][NW-1:0] dv_rem_reg  [0:QW-1];
    logic [2:0][QW-1:0] dv_q_reg    [0:QW-1];
    logic [RW-1:0]      dv_den_reg  [0:QW-1];
    logic [2:0]         dv_sgn_reg  [0:QW-1];
    logic               dv_zero_reg [0:QW-1];
    logic [SBW-1:0]     dv_side_reg [0:QW-1];
    logic               dv_v_reg    [0:QW-1];

    for (genvar k = 0; k < QW; k++)
    begin : g_div
        logic [2:0][NW-1:0] rem_in;
        logic [2:0][QW-1:0] q_in;
        logic [RW-1:0]      den_in;
        logic [2:0]         sgn_in;
        logic               zero_in;
        logic [SBW-1:0]     side_in;
        logic               v_in;
        logic [2:0][NW-1:0] rem_next;
        logic [2:0][QW-1:0] q_next;
        logic [DW-1:0]      cmp;
        logic [DW-1:0]      rem_w;

        if (k == 0)
        begin : g_src
            for (genvar j = 0; j < 3; j++)
            begin : g_lane
                assign rem_in[j] = {sr_mag_reg[RW][j], {(16 + G){1'b0}}};
            end
            assign q_in    = '0;
            assign den_in  = sr_root_reg[RW];
            assign sgn_in  = sr_sgn_reg[RW];
            assign zero_in = sr_zero_reg[RW];
            assign side_in = sr_side_reg[RW];
            assign v_in    = sr_v_reg[RW];
        end
        else
        begin : g_src
            assign rem_in  = dv_rem_reg[k-1];
            assign q_in    = dv_q_reg[k-1];
            assign den_in  = dv_den_reg[k-1];
            assign sgn_in  = dv_sgn_reg[k-1];
            assign zero_in = dv_zero_reg[k-1];
            assign side_in = dv_side_reg[k-1];
            assign v_in    = dv_v_reg[k-1];
        end

        // Subtract the shifted divisor where it fits
        always_comb
        begin
            cmp = DW'(den_in) << (QW - 1 - k);
            for (int j = 0; j < 3; j++)
            begin
                rem_w = DW'(rem_in[j]);
                if (rem_w >= cmp)
                begin
                    rem_next[j] = NW'(rem_w - cmp);
                    q_next[j]   = {q_in[j][QW-2:0], 1'b1};
                end
                else
                begin
                    rem_next[j] = rem_in[j];
                    q_next[j]   = {q_in[j][QW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_rem_reg[k]  <= rem_next;
                dv_q_reg[k]    <= q_next;
                dv_den_reg[k]  <= den_in;
                dv_sgn_reg[k]  <= sgn_in;
                dv_zero_reg[k] <= zero_in;
                dv_side_reg[k] <= side_in;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_v_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                dv_v_reg[k] <= v_in;
            end
        end
    end

    // Output stage: restore signs, straight up for a zero vector
    hne_pkg::comp_t [2:0] o_next, o_reg;
    logic [SBW-1:0]       o_side_reg;
    logic                 o_v_reg;

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            if (dv_zero_reg[QW-1])
            begin
                o_next[j] = (j == 1) ? hne_pkg::ONE_Q16 : '0;
            end
            else if (dv_sgn_reg[QW-1][j])
            begin
                o_next[j] = -hne_pkg::comp_t'({1'b0, dv_q_reg[QW-1][j]});
            end
            else
            begin
                o_next[j] = hne_pkg::comp_t'({1'b0, dv_q_reg[QW-1][j]});
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            o_reg      <= o_next;
            o_side_reg <= dv_side_reg[QW-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_v_reg <= 1'b0;
        end
        else if (en)
        begin
            o_v_reg <= dv_v_reg[QW-1];
        end
    end

    assign out_valid = o_v_reg;
    assign out_x     = o_reg[0];
    assign out_y     = o_reg[1];
    assign out_z     = o_reg[2];
    assign out_side  = o_side_reg;
endmodule
`default_nettype wire

@@ dv/tb_top.sv @@
// Testbench for the heightmap normal encoder: predicts each encoded normal and checks it.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
    localparam int HB = 8;
    localparam int N_RANDOM = 530;
    localparam int DRAIN_CYCLES = 200;

    typedef struct packed {
        logic [15:0] z;
        logic [15:0] x;
        logic [15:0] y;
    } enc_normal_t;

    // Track expected normals and compare arrivals in order
    class normal_scoreboard;
        enc_normal_t pending[$];
        int errors;

        function new();
            errors = 0;
        endfunction

        // Integer square root, floor
        function automatic longint unsigned isqrt(longint unsigned v);
            longint unsigned r;
            longint unsigned b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v)
                b >>= 2;
            while (b != 0)
            begin
                if (v >= r + b)
                begin
                    v -= r + b;
                    r = (r >> 1) + b;
                end
                else
                begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return r;
        endfunction

        // Scale a vector to Q.16 unit length, length held with g fraction bits
        function automatic void unitize(input longint v[3], input int g, output longint o[3]);
            longint unsigned len2;
            longint unsigned s;
            longint mul;
            len2 = 0;
            for (int i = 0; i < 3; i++)
                len2 += longint'(v[i] * v[i]);
            if (len2 == 0)
            begin
                o[0] = 0;
                o[1] = 65536;
                o[2] = 0;
                return;
            end
            s = isqrt(len2 << (2 * g));
            mul = longint'(64'd1 << (16 + g));
            for (int i = 0; i < 3; i++)
                o[i] = (v[i] * mul) / longint'(s);
        endfunction

        function automatic logic [15:0] to_q016(longint c);
            longint t;
            t = c + 65536;
            if (t < 0)
                t = 0;
            t = t >>> 1;
            if (t > 65535)
                t = 65535;
            return t[15:0];
        endfunction

        // Note an accepted input window and queue its encoded normal
        function void note_window(logic [HB-1:0] h[9], logic inner);
            longint hc, dn, ds, de, dw, dne, dse, dnw, dsw;
            longint v[3], u[3], f[3], acc[3];
            enc_normal_t e;
            hc = h[0];
            dn = longint'(h[1]) - hc;
            ds = longint'(h[2]) - hc;
            de = longint'(h[3]) - hc;
            dw = longint'(h[4]) - hc;
            dne = longint'(h[5]) - hc;
            dse = longint'(h[6]) - hc;
            dnw = longint'(h[7]) - hc;
            dsw = longint'(h[8]) - hc;
            v = '{-ds, 1, -de};
            unitize(v, hne_pkg::G_FIRST, f);
            if (inner)
            begin
                acc = f;
                v = '{dn, 1, dw};
                unitize(v, hne_pkg::G_FIRST, u);
                for (int i = 0; i < 3; i++) acc[i] += u[i];
                v = '{-dne - dse, 2, dse - dne};
                unitize(v, hne_pkg::G_FIRST, u);
                for (int i = 0; i < 3; i++) acc[i] += u[i];
                v = '{dsw + dnw, 2, dsw - dnw};
                unitize(v, hne_pkg::G_FIRST, u);
                for (int i = 0; i < 3; i++) acc[i] += u[i];
                unitize(acc, hne_pkg::G_SECOND, f);
            end
            e.z = to_q016(f[2]);
            e.x = to_q016(f[0]);
            e.y = to_q016(f[1]);
            pending.push_back(e);
        endfunction

        // Compare one output transaction with the oldest expectation
        function void check_normal(logic [15:0] z, logic [15:0] x, logic [15:0] y);
            enc_normal_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected output z=%0d x=%0d y=%0d", z, x, y);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (z !== e.z)
            begin
                $error("enc_z expected %0d actual %0d", e.z, z);
                errors++;
            end
            if (x !== e.x)
            begin
                $error("enc_x expected %0d actual %0d", e.x, x);
                errors++;
            end
            if (y !== e.y)
            begin
                $error("enc_y expected %0d actual %0d", e.y, y);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [HB-1:0] h_center = '0, h_north = '0, h_south = '0, h_east = '0, h_west = '0;
    logic [HB-1:0] h_northeast = '0, h_southeast = '0, h_northwest = '0, h_southwest = '0;
    logic interior = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [15:0] enc_z, enc_x, enc_y;
    logic calm = 1'b0;

    normal_scoreboard sb = new();

    heightmap_normal_encode_top #(.HEIGHT_BITS(HB)) dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .h_center(h_center), .h_north(h_north), .h_south(h_south),
        .h_east(h_east), .h_west(h_west),
        .h_northeast(h_northeast), .h_southeast(h_southeast),
        .h_northwest(h_northwest), .h_southwest(h_southwest),
        .interior(interior),
        .out_valid(out_valid), .out_ready(out_ready),
        .enc_z(enc_z), .enc_x(enc_x), .enc_y(enc_y)
    );

    always #6 clk = ~clk;

    // Note accepted inputs and check accepted outputs at each edge
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            sb.note_window('{h_center, h_north, h_south, h_east, h_west,
                             h_northeast, h_southeast, h_northwest, h_southwest}, interior);
        if (rst_n && out_valid && out_ready)
            sb.check_normal(enc_z, enc_x, enc_y);
    end

    // Stall the receiver in random bursts until the calm part
    initial
    begin
        int n;
        @(posedge rst_n);
        forever
        begin
            if (!calm && $urandom_range(0, 5) == 0)
            begin
                n = $urandom_range(1, 5);
                out_ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Present one window and hold it until accepted
    task automatic send_window(logic [HB-1:0] h[9], logic inner);
        int n;
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            n = $urandom_range(1, 5);
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        in_valid <= 1'b1;
        h_center <= h[0]; h_north <= h[1]; h_south <= h[2];
        h_east <= h[3]; h_west <= h[4]; h_northeast <= h[5];
        h_southeast <= h[6]; h_northwest <= h[7]; h_southwest <= h[8];
        interior <= inner;
        do @(posedge clk); while (!in_ready);
    endtask

    initial
    begin
        logic [HB-1:0] h[9];
        logic [HB-1:0] base;
        int mode;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: flat, extremes, steep slopes, alternating patterns
        for (int k = 0; k < 20; k++)
        begin
            for (int i = 0; i < 9; i++)
            begin
                case (k % 5)
                    0: h[i] = (k < 10) ? '0 : '1;
                    1: h[i] = (i == 0) ? '0 : '1;
                    2: h[i] = (i == 0) ? '1 : '0;
                    3: h[i] = i[0] ? '1 : '0;
                    default: h[i] = i[0] ? '0 : '1;
                endcase
            end
            send_window(h, k[0]);
        end
        in_valid <= 1'b0;

        // Let the pipeline drain completely before random traffic
        while (sb.pending.size() != 0) @(posedge clk);

        for (int k = 0; k < N_RANDOM; k++)
        begin
            if (k == N_RANDOM - 80)
                calm = 1'b1;
            mode = $urandom_range(0, 3);
            base = HB'($urandom);
            for (int i = 0; i < 9; i++)
            begin
                if (mode == 0)
                    h[i] = HB'($urandom);
                else if (mode == 1)
                    h[i] = HB'(base + $urandom_range(0, 6) - 3);
                else if (mode == 2)
                    h[i] = $urandom_range(0, 1) ? '1 : '0;
                else
                    h[i] = HB'(base + $urandom_range(0, 40) - 20);
            end
            send_window(h, $urandom_range(0, 3) != 0);
        end
        in_valid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("heightmap_normal_encode_top regression: pass");
        else
            $display("heightmap_normal_encode_top regression: fail");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2000000;
        $display("heightmap_normal_encode_top regression: fail");
        $finish;
    end
endmodule
`default_nettype wire
